### rtl/core/sgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared constants, types and the tortuosity power table for the soil gas
// diffusivity pipeline.
// ----------------------------------------------------------------------------
package sgd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FW         = FRAC_BITS + 1;
  localparam int IO_W       = 16;
  localparam int TAB_BITS   = 8;
  localparam int TAB_N      = 1 << TAB_BITS;
  localparam int TAB_IDX_W  = TAB_BITS + 1;
  localparam int DIV_LAT    = FW;
  localparam int DIV_Q_W    = FW;
  localparam int DIV_DEN_W  = FW + 1;
  localparam int DIV_NUM_W  = 2 * FW;
  localparam int TORT_LAT   = 2;

  localparam logic [FW-1:0]   ONE_Q    = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0]   OUT_MAX  = FW'((1 << IO_W) - 1);
  localparam logic [IO_W-1:0] PD_RESET = 16'd43418;
  localparam logic [63:0]     Q30      = 64'h1 << 30;
  localparam logic [63:0]     EXP_BASE = 64'd1245540516;

  typedef logic [FW-1:0] tab_t [0:TAB_N];

  typedef struct packed {
    logic [IO_W-1:0] a;
    logic [IO_W-1:0] w;
    logic            p0;
  } b_side_t;

  typedef struct packed {
    logic          sfull;
    logic          wfull;
    logic [FW-1:0] dp;
    logic [FW-1:0] tp5;
    logic          deg;
  } d_side_t;

  typedef struct packed {
    logic [FW-1:0] tp1;
    logic [FW-1:0] tp7;
    logic [FW-1:0] tp5;
    logic          deg;
  } e_side_t;

  typedef struct packed {
    logic          zero;
    logic [FW-1:0] p76;
    logic          deg;
  } h_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] power_entry(input int k);
    logic [63:0] kk;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] neg;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] res;
    logic [31:0] n;
    int          e;
    kk = 64'(k);
    if (k == 0) return '0;
    e = 0;
    for (int i = 0; i < 31; i++) begin
      if ((kk >> (i + 1)) != 0) e = i + 1;
    end
    m  = (kk << 30) >> e;
    lg = 64'(e) << 30;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (Q30 << 1)) begin
        m  = m >> 1;
        lg = lg | (64'h1 << (30 - i));
      end
    end
    neg = (64'(TAB_BITS) << 30) - lg;
    y   = EXP_BASE + ((kk << 29) >> TAB_BITS);
    z   = (neg * (y >> 4)) >> 26;
    n   = 32'(z >> 30);
    r   = z & (Q30 - 64'h1);
    c   = Q30 >> 1;
    res = Q30;
    for (int i = 1; i <= 30; i++) begin
      c = isqrt64(c << 30);
      if (r[30 - i]) res = (res * c) >> 30;
    end
    if (n >= 32'd63) return '0;
    return res >> n;
  endfunction

  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] v;
    for (int k = 0; k <= TAB_N; k++) begin
      v    = power_entry(k);
      t[k] = FW'((v + (64'h1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return t;
  endfunction

  localparam tab_t POWER_TAB = build_tab();

endpackage
`default_nettype wire

### rtl/core/sgd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_ifs
// Valid/ready channels for soil items in and diffusivity results out.
// ----------------------------------------------------------------------------
interface sgd_in_if;
  import sgd_pkg::*;

  logic            valid;
  logic            ready;
  logic [IO_W-1:0] field_capacity_fraction;
  logic [IO_W-1:0] bulk_density;
  logic [IO_W-1:0] water_filled_pore_space;

  modport source (output valid, output field_capacity_fraction, output bulk_density,
                  output water_filled_pore_space, input ready);
  modport sink (input valid, input field_capacity_fraction, input bulk_density,
                input water_filled_pore_space, output ready);
endinterface

interface sgd_out_if;
  import sgd_pkg::*;

  logic            valid;
  logic            ready;
  logic [IO_W-1:0] diffusivity;
  logic            degenerate;

  modport source (output valid, output diffusivity, output degenerate, input ready);
  modport sink (input valid, input diffusivity, input degenerate, output ready);
endinterface
`default_nettype wire

### rtl/core/sgd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_div
// Pipelined restoring divider, one quotient bit per stage. Quotient must fit
// in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module sgd_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [sgd_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [sgd_pkg::DIV_DEN_W-1:0]  den,
  output      logic [sgd_pkg::DIV_Q_W-1:0]    quo
);
  import sgd_pkg::*;

  logic [DIV_NUM_W-1:0] rem  [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] dv   [0:DIV_LAT-1];
  logic [DIV_Q_W-1:0]   qacc [0:DIV_LAT-1];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    localparam int SH = DIV_LAT - 1 - i;
    logic [DIV_NUM_W-1:0] r_in;
    logic [DIV_NUM_W-1:0] trial;
    logic [DIV_DEN_W-1:0] d_in;
    logic [DIV_Q_W-1:0]   q_in;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign q_in = qacc[i-1];
    end

    assign trial = DIV_NUM_W'(d_in) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i] <= d_in;
        if (r_in >= trial) begin
          rem[i]  <= r_in - trial;
          qacc[i] <= q_in | (DIV_Q_W'(1) << SH);
        end else begin
          rem[i]  <= r_in;
          qacc[i] <= q_in;
        end
      end
    end
  end

  assign quo = qacc[DIV_LAT-1];

endmodule
`default_nettype wire

### rtl/core/sgd_tort.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_tort
// Tortuosity term x^(0.5x+1.16): table lookup, then linear interpolation.
// Two register stages.
// ----------------------------------------------------------------------------
module sgd_tort (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [sgd_pkg::FW-1:0]  x,
  output      logic [sgd_pkg::FW-1:0]  y
);
  import sgd_pkg::*;

  logic [TAB_IDX_W-1:0] idx;
  logic [FW-1:0]        t0;
  logic [FW-1:0]        t1;
  logic [FRAC_BITS-1:0] frac;
  logic [FW-1:0]        base;
  logic [FW-1:0]        diff;
  logic [FRAC_BITS-1:0] wgt;
  logic [FW+FRAC_BITS-1:0] prod;

  always_comb begin
    idx  = {1'b0, x[FRAC_BITS-1 -: TAB_BITS]};
    frac = {x[FRAC_BITS-TAB_BITS-1:0], TAB_BITS'(0)};
    if (x >= ONE_Q) begin
      idx  = TAB_IDX_W'(TAB_N);
      frac = '0;
    end
    t0 = POWER_TAB[idx];
    t1 = (x >= ONE_Q) ? t0 : POWER_TAB[idx + TAB_IDX_W'(1)];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base <= t0;
      diff <= (t1 > t0) ? t1 - t0 : '0;
      wgt  <= frac;
    end
  end

  assign prod = (FW + FRAC_BITS)'(diff) * (FW + FRAC_BITS)'(wgt);

  always_ff @(posedge clk) begin
    if (en) begin
      y <= base + FW'(prod >> FRAC_BITS);
    end
  end

endmodule
`default_nettype wire

### rtl/core/soil_gas_diffusivity_top.sv
// Throughput: one item per cycle while not stalled; three 17-stage pipelined
// dividers in series (one quotient bit per stage) set the depth.
// Stall: one global enable freezes the pipe; a skid register behind the output
// register keeps input ready up while a result waits, until the skid fills.
// Reset: rst clears all valid bits and loads particle density 2.65 (43418).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soil_gas_diffusivity_top
// Normalized gas diffusivity of aggregated soil from field capacity fraction,
// bulk density and water-filled pore space.
// ----------------------------------------------------------------------------
module soil_gas_diffusivity_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sgd_pkg::IO_W-1:0]  cfg_wr_data,
  sgd_in_if.sink                         in_item,
  sgd_out_if.source                      out_item
);
  import sgd_pkg::*;

  function automatic logic [FW-1:0] sq_comp(input logic [FW-1:0] s);
    logic [FW-1:0]   d;
    logic [2*FW-1:0] p;
    d = (s >= ONE_Q) ? '0 : ONE_Q - s;
    p = (2*FW)'(d) * (2*FW)'(d);
    return FW'(p >> FRAC_BITS);
  endfunction

  logic [IO_W-1:0] pd;
  logic            en;

  // input register
  logic            s0_v;
  logic [IO_W-1:0] s0_a;
  logic [IO_W-1:0] s0_bd;
  logic [IO_W-1:0] s0_w;

  // porosity division
  b_side_t          b_line [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] b_v;
  logic [DIV_Q_W-1:0] q1;
  b_side_t          bl;

  logic          c1_v, c2_v, c3_v;
  logic [FW-1:0] c1_p;
  logic [IO_W-1:0] c1_a, c1_w;
  logic [FW-1:0] c2_p, c2_tv, c2_dp;
  logic [IO_W-1:0] c2_a;
  logic          c2_deg;
  logic [2*FW-2:0] tv_prod;
  logic [FW-1:0] tv_raw;
  logic [FW-1:0] a17;
  logic [FW-1:0] c1_a17;
  logic [FW-1:0] th_p, th_a;

  logic          c3_sfull, c3_wfull, c3_deg;
  logic [FW-1:0] c3_dp, c3_tp5, c3_tv, c3_thp, c3_na, c3_a;
  logic [DIV_DEN_W-1:0] c3_dn;

  // saturation divisions
  d_side_t          d_line [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] d_v;
  d_side_t          dl;
  logic [DIV_Q_W-1:0] qs, qw, qt;
  logic [FW-1:0]    sval, wval;
  logic [FW-1:0]    y2, yd, y5;

  e_side_t          e_line [0:TORT_LAT-1];
  logic [TORT_LAT-1:0] e_v;
  e_side_t          el;

  logic          f1_v, f2_v, f3_v;
  logic [FW-1:0] tp6;
  logic [2*FW-1:0] m1_prod, p76_prod, x_prod;
  logic [FW-1:0] f1_m1, f1_tp4, f1_g, f1_p76;
  logic          f1_deg;
  logic [FW-1:0] f2_x, f2_g, f2_p76;
  logic          f2_deg;
  logic [DIV_NUM_W-1:0] f3_num;
  logic [DIV_DEN_W-1:0] f3_den;
  logic [FW-1:0] f3_p76;
  logic          f3_deg;

  // series term division
  h_side_t          h_line [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] h_v;
  h_side_t          hl;
  logic [DIV_Q_W-1:0] q3;
  logic [FW-1:0]    term;
  logic [FW:0]      dsum;
  logic [FW-1:0]    dclamp;
  logic [IO_W-1:0]  pipe_diff;
  logic             pipe_v;

  logic            out_v, skid_v;
  logic [IO_W-1:0] out_diff, skid_diff;
  logic            out_deg, skid_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      pd <= PD_RESET;
    end else if (cfg_wr_en) begin
      pd <= cfg_wr_data;
    end
  end

  assign en            = !skid_v;
  assign in_item.ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      b_v  <= '0;
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      d_v  <= '0;
      e_v  <= '0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      h_v  <= '0;
    end else if (en) begin
      s0_v <= in_item.valid;
      b_v  <= {b_v[DIV_LAT-2:0], s0_v};
      c1_v <= b_v[DIV_LAT-1];
      c2_v <= c1_v;
      c3_v <= c2_v;
      d_v  <= {d_v[DIV_LAT-2:0], c3_v};
      e_v  <= {e_v[TORT_LAT-2:0], d_v[DIV_LAT-1]};
      f1_v <= e_v[TORT_LAT-1];
      f2_v <= f1_v;
      f3_v <= f2_v;
      h_v  <= {h_v[DIV_LAT-2:0], f3_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a  <= in_item.field_capacity_fraction;
      s0_bd <= in_item.bulk_density;
      s0_w  <= in_item.water_filled_pore_space;
    end
  end

  // porosity: one minus bulk / particle density
  sgd_div u_div_por (
    .clk (clk),
    .en  (en),
    .num (DIV_NUM_W'({s0_bd, FRAC_BITS'(0)})),
    .den (DIV_DEN_W'(pd)),
    .quo (q1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      b_line[0] <= '{a: s0_a, w: s0_w, p0: (pd == '0) || (s0_bd >= pd)};
      for (int i = 1; i < DIV_LAT; i++) b_line[i] <= b_line[i-1];
    end
  end
  assign bl = b_line[DIV_LAT-1];

  assign c1_a17  = FW'(c1_a);
  assign tv_prod = (2*FW-1)'(c1_w) * (2*FW-1)'(c1_p);
  assign tv_raw  = FW'(tv_prod >> FRAC_BITS);
  assign a17     = FW'(c2_a);
  assign th_p    = (c2_tv > a17) ? c2_tv - a17 : '0;
  assign th_a    = (c2_tv < a17) ? c2_tv : a17;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p   <= bl.p0 ? '0 : ONE_Q - q1;
      c1_a   <= bl.a;
      c1_w   <= bl.w;
      c2_deg <= (c1_a == '0) || (c1_p <= c1_a17);
      c2_tv  <= (tv_raw > c1_p) ? c1_p : tv_raw;
      c2_dp  <= (c1_p > c1_a17) ? c1_p - c1_a17 : '0;
      c2_a   <= c1_a;
      c2_p   <= c1_p;
      c3_sfull <= c2_tv >= a17;
      c3_wfull <= th_p >= c2_dp;
      c3_dp    <= c2_dp;
      c3_tp5   <= (c2_dp > th_p) ? c2_dp - th_p : '0;
      c3_deg   <= c2_deg;
      c3_tv    <= c2_tv;
      c3_thp   <= th_p;
      c3_na    <= a17 - th_a;
      c3_a     <= a17;
      c3_dn    <= DIV_DEN_W'(a17) + DIV_DEN_W'(ONE_Q) - DIV_DEN_W'(c2_p);
    end
  end

  // saturations and intra-aggregate tortuosity argument
  sgd_div u_div_s (
    .clk (clk),
    .en  (en),
    .num (DIV_NUM_W'({c3_tv, FRAC_BITS'(0)})),
    .den (DIV_DEN_W'(c3_a)),
    .quo (qs)
  );

  sgd_div u_div_w (
    .clk (clk),
    .en  (en),
    .num (DIV_NUM_W'({c3_thp, FRAC_BITS'(0)})),
    .den (DIV_DEN_W'(c3_dp)),
    .quo (qw)
  );

  sgd_div u_div_t (
    .clk (clk),
    .en  (en),
    .num (DIV_NUM_W'({c3_na, FRAC_BITS'(0)})),
    .den (c3_dn),
    .quo (qt)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_line[0] <= '{sfull: c3_sfull, wfull: c3_wfull, dp: c3_dp, tp5: c3_tp5,
                     deg: c3_deg};
      for (int i = 1; i < DIV_LAT; i++) d_line[i] <= d_line[i-1];
    end
  end
  assign dl = d_line[DIV_LAT-1];

  assign sval = dl.sfull ? ONE_Q : qs;
  assign wval = dl.wfull ? ONE_Q : qw;

  sgd_tort u_tort_t (.clk(clk), .en(en), .x(qt),     .y(y2));
  sgd_tort u_tort_d (.clk(clk), .en(en), .x(dl.dp),  .y(yd));
  sgd_tort u_tort_5 (.clk(clk), .en(en), .x(dl.tp5), .y(y5));

  always_ff @(posedge clk) begin
    if (en) begin
      e_line[0] <= '{tp1: sq_comp(sval), tp7: sq_comp(wval), tp5: dl.tp5, deg: dl.deg};
      for (int i = 1; i < TORT_LAT; i++) e_line[i] <= e_line[i-1];
    end
  end
  assign el = e_line[TORT_LAT-1];

  assign tp6      = (el.tp5 != '0) ? y5 : '0;
  assign m1_prod  = (2*FW)'(el.tp1) * (2*FW)'(y2);
  assign p76_prod = (2*FW)'(el.tp7) * (2*FW)'(tp6);
  assign x_prod   = (2*FW)'(f1_m1) * (2*FW)'(f1_tp4);

  always_ff @(posedge clk) begin
    if (en) begin
      f1_m1  <= FW'(m1_prod >> FRAC_BITS);
      f1_p76 <= FW'(p76_prod >> FRAC_BITS);
      f1_tp4 <= ONE_Q - yd;
      f1_g   <= (el.tp5 > tp6) ? el.tp5 - tp6 : '0;
      f1_deg <= el.deg;
      f2_x   <= FW'(x_prod >> FRAC_BITS);
      f2_g   <= f1_g;
      f2_p76 <= f1_p76;
      f2_deg <= f1_deg;
      f3_num <= DIV_NUM_W'(f2_x) * DIV_NUM_W'(f2_g);
      f3_den <= DIV_DEN_W'(f2_x) + DIV_DEN_W'(f2_g);
      f3_p76 <= f2_p76;
      f3_deg <= f2_deg;
    end
  end

  // series combination X*g / (X+g)
  sgd_div u_div_ser (
    .clk (clk),
    .en  (en),
    .num (f3_num),
    .den (f3_den),
    .quo (q3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      h_line[0] <= '{zero: f3_den == '0, p76: f3_p76, deg: f3_deg};
      for (int i = 1; i < DIV_LAT; i++) h_line[i] <= h_line[i-1];
    end
  end
  assign hl = h_line[DIV_LAT-1];

  assign term      = hl.zero ? '0 : q3;
  assign dsum      = (FW+1)'(term) + (FW+1)'(hl.p76);
  assign dclamp    = (dsum > (FW+1)'(ONE_Q)) ? ONE_Q : FW'(dsum);
  assign pipe_diff = hl.deg ? '0 : ((dclamp > OUT_MAX) ? IO_W'(OUT_MAX) : IO_W'(dclamp));
  assign pipe_v    = h_v[DIV_LAT-1];

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_item.ready) begin
        out_diff <= skid_diff;
        out_deg  <= skid_deg;
        skid_v   <= 1'b0;
      end
    end else if (!out_v || out_item.ready) begin
      out_v    <= pipe_v;
      out_diff <= pipe_diff;
      out_deg  <= hl.deg;
    end else if (pipe_v) begin
      skid_v    <= 1'b1;
      skid_diff <= pipe_diff;
      skid_deg  <= hl.deg;
    end
  end

  assign out_item.valid       = out_v;
  assign out_item.diffusivity = out_diff;
  assign out_item.degenerate  = out_deg;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds an item while output register is empty");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && out_deg |-> out_diff == '0)
    else $error("degenerate result with nonzero diffusivity");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s0_v && !en |=> s0_v && $stable(s0_a))
    else $error("input stage lost an item during stall");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_v && !skid_v)
    else $error("output not empty after reset");
`endif

endmodule
`default_nettype wire

### tb/soil_gas_diffusivity_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soil_gas_diffusivity_top_test
// Self-checking test of the soil gas diffusivity pipeline. A local fixed
// point predictor computes each expected result; a monitor compares results
// in order while both channels idle at random.
// ----------------------------------------------------------------------------
module soil_gas_diffusivity_top_test;
  import sgd_pkg::*;

  localparam int      FB    = 16;
  localparam int      TN    = 256;
  localparam longint  ONE   = 64'h1 << FB;
  localparam longint  EPS   = (ONE + 500000) / 1000000;
  localparam int      LIMIT = 20000;

  typedef struct packed {
    logic [15:0] diffusivity;
    logic        degenerate;
  } soil_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  sgd_in_if  in_item ();
  sgd_out_if out_item ();

  soil_gas_diffusivity_top i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_item(in_item.sink), .out_item(out_item.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint       tort_tab [0:TN];
  logic [15:0]  density;
  soil_result_t pending_results [$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           idle_cycles = 0;
  int           sink_gap = 0;
  int           hold_off = 0;
  bit           quiet = 1'b0;

  function automatic longint root64(longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned power_point(int k);
    longint unsigned m, lg, neg, y, z, r, c, res, q30;
    int e, n;
    q30 = 64'h1 << 30;
    if (k == 0) return 0;
    e = 0;
    while (e < 31 && (k >> (e + 1)) != 0) e++;
    m  = (longint'(k) << 30) >> e;
    lg = longint'(e) << 30;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (q30 << 1)) begin
        m  = m >> 1;
        lg = lg | (64'h1 << (30 - i));
      end
    end
    neg = (64'd8 << 30) - lg;
    y   = 64'd1245540516 + ((longint'(k) << 29) >> 8);
    z   = (neg * (y >> 4)) >> 26;
    n   = int'(z >> 30);
    r   = z & (q30 - 1);
    c   = q30 >> 1;
    res = q30;
    for (int i = 1; i <= 30; i++) begin
      c = root64(c << 30);
      if ((r >> (30 - i)) & 1) res = (res * c) >> 30;
    end
    return n >= 63 ? 0 : (res >> n);
  endfunction

  function automatic longint tortuosity(longint x);
    longint pos, idx, frac, t0, t1;
    if (x >= ONE) return tort_tab[TN];
    pos  = x << 8;
    idx  = pos >> FB;
    frac = pos & (ONE - 1);
    t0   = tort_tab[idx];
    t1   = tort_tab[idx + 1];
    if (t1 <= t0) return t0;
    return t0 + (((t1 - t0) * frac) >> FB);
  endfunction

  function automatic longint sq_complement(longint s);
    longint d;
    d = s >= ONE ? 0 : ONE - s;
    return (d * d) >> FB;
  endfunction

  function automatic soil_result_t predict_diffusivity(logic [15:0] fc, logic [15:0] bd,
                                                        logic [15:0] wf);
    longint a, w, q, p, tv, thp, tha, dd, s, swp, t1, t7, t2, t3, t4, t5, t6, g, x, den, term,
            d;
    soil_result_t res;
    a = fc;
    w = wf;
    p = 0;
    if (density != 0) begin
      q = (longint'(bd) << FB) / density;
      p = q >= ONE ? 0 : ONE - q;
    end
    if (a == 0 || p <= a) begin
      res.diffusivity = '0;
      res.degenerate  = 1'b1;
      return res;
    end
    tv  = (w * p) >> FB;
    if (tv > p) tv = p;
    thp = tv > a ? tv - a : 0;
    tha = tv < a ? tv : a;
    dd  = p - a;
    s   = tv >= a ? ONE : (tv << FB) / a;
    swp = thp >= dd ? ONE : (thp << FB) / dd;
    t1  = sq_complement(s);
    t7  = sq_complement(swp);
    t2  = ((a - tha) << FB) / (a + ONE - p);
    t3  = tortuosity(t2);
    t4  = ONE - tortuosity(dd);
    t5  = dd > thp ? dd - thp : 0;
    t6  = t5 > 0 ? tortuosity(t5) : 0;
    g   = t5 > t6 ? t5 - t6 : 0;
    x   = (((t1 * t3) >> FB) * t4) >> FB;
    den = EPS + x + g;
    term = den != 0 ? (x * g) / den : 0;
    d   = term + ((t7 * t6) >> FB);
    if (d > ONE) d = ONE;
    if (d > 65535) d = 65535;
    res.diffusivity = d[15:0];
    res.degenerate  = 1'b0;
    return res;
  endfunction

  initial begin
    for (int k = 0; k <= TN; k++)
      tort_tab[k] = (power_point(k) + (64'h1 << (29 - FB))) >> (30 - FB);
  end

  task automatic send_soil(logic [15:0] fc, logic [15:0] bd, logic [15:0] wf);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(13, 1);
      in_item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item.valid                   <= 1'b1;
    in_item.field_capacity_fraction <= fc;
    in_item.bulk_density            <= bd;
    in_item.water_filled_pore_space <= wf;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    pending_results.push_back(predict_diffusivity(fc, bd, wf));
  endtask

  task automatic drain();
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_density(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    density = v;
    @(posedge clk);
  endtask

  task automatic random_soil();
    logic [15:0] fc, bd, wf;
    fc = 16'($urandom);
    bd = 16'($urandom);
    wf = 16'($urandom);
    if ($urandom_range(9) < 8) begin
      fc = 16'($urandom_range(30000, 1));
      bd = 16'($urandom_range(int'(density) / 2));
    end
    send_soil(fc, bd, wf);
  endtask

  task automatic test_directed();
    send_soil(16'd0, 16'd20000, 16'd30000);
    send_soil(16'd1000, 16'd65535, 16'd30000);
    send_soil(16'd10000, 16'd0, 16'd0);
    send_soil(16'd10000, 16'd0, 16'd65535);
    send_soil(16'd65535, 16'd0, 16'd30000);
    send_soil(16'd1, 16'd0, 16'd65535);
    send_soil(16'd1, 16'd0, 16'd0);
    send_soil(16'd30000, 16'd20000, 16'd32768);
    send_soil(16'd20000, 16'd43418, 16'd40000);
    send_soil(16'd20000, 16'd43417, 16'd40000);
    send_soil(16'd5000, 16'd10000, 16'd10000);
    send_soil(16'd32767, 16'd1, 16'd65535);
    send_soil(16'd40000, 16'd12000, 16'd1);
    send_soil(16'd65535, 16'd65535, 16'd65535);
  endtask

  task automatic test_density_settings();
    write_density(16'd0);
    send_soil(16'd1000, 16'd0, 16'd1000);
    send_soil(16'd0, 16'd0, 16'd0);
    write_density(16'd16384);
    repeat (60) random_soil();
    write_density(16'd65535);
    repeat (60) random_soil();
    write_density(16'($urandom_range(65535, 16384)));
    repeat (60) random_soil();
    write_density(16'd43418);
  endtask

  task automatic test_backpressure();
    hold_off = 200;
    repeat (120) random_soil();
    drain();
  endtask

  task automatic test_random();
    repeat (560) random_soil();
    quiet = 1'b1;
    repeat (80) random_soil();
    drain();
  endtask

  initial begin
    in_item.valid                   = 1'b0;
    in_item.field_capacity_fraction = '0;
    in_item.bulk_density            = '0;
    in_item.water_filled_pore_space = '0;
    out_item.ready                  = 1'b0;
    density = 16'd43418;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_density_settings();
    test_backpressure();
    test_random();
    $display("Checked %0d results over five density settings, degenerate cases,", results_seen);
    $display("random idling and a long output stall.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // count down the long receiver stall
  always @(posedge clk) begin
    if (hold_off > 0) hold_off--;
  end

  always @(posedge clk) begin
    soil_result_t exp_res;
    if (rst) begin
      out_item.ready <= 1'b0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %0d", out_item.diffusivity);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_item.diffusivity !== exp_res.diffusivity ||
              out_item.degenerate !== exp_res.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %0d/%0b, got %0d/%0b", exp_res.diffusivity,
                       exp_res.degenerate, out_item.diffusivity, out_item.degenerate);
          end
        end
      end
      if (hold_off > 0) begin
        out_item.ready <= 1'b0;
      end else if (quiet) begin
        out_item.ready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_item.ready <= 1'b0;
      end else if ($urandom_range(3) == 0) begin
        sink_gap = $urandom_range(12, 0);
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule
